// ===== hdl/jones_calibration_apply_assert.svh =====
// Assertion macros used by the calibration checker
`ifndef JONES_CALIBRATION_APPLY_ASSERT_SVH
`define JONES_CALIBRATION_APPLY_ASSERT_SVH

// same-cycle implication
`define JCA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jca assertion failed");

// next-cycle implication
`define JCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jca assertion failed");

`endif

// ===== hdl/jca_pkg.sv =====
// Types, constants and helper functions of the Jones calibration block
`timescale 1ns / 1ps

package jca_pkg;

   localparam int ANTENNAS     = 128;
   localparam int SOL_CHANNELS = 384;

   localparam int IDX_W    = 14;
   localparam int CH_W     = 12;
   localparam int W        = 32;
   localparam int COARSE_W = 5;
   localparam int SPB_W    = 5;
   localparam int FC_W     = 13;
   localparam int ST_W     = 2;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam int ANT_W   = (ANTENNAS > 1) ? $clog2(ANTENNAS) : 1;
   localparam int SOL_W   = $clog2(SOL_CHANNELS);
   localparam int NBASE   = ANTENNAS * (ANTENNAS + 1) / 2;
   localparam int DEPTH   = ANTENNAS * SOL_CHANNELS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int TRI_W   = (2 * ANT_W > IDX_W) ? 2 * ANT_W : IDX_W;
   localparam int SC_W    = CH_W + FC_W + 1;
   localparam int DIV_SPLIT = FC_W / 2;
   localparam int ANT_SPLIT = ANT_W / 2;

   localparam int DATA_LSB = IDX_W + CH_W;
   localparam int PAY_W    = DATA_LSB + 8 * W;
   localparam int TDATA_W  = ((PAY_W + 7) / 8) * 8;

   localparam logic [0:0] FUNC_LOAD  = 1'b0;
   localparam logic [0:0] FUNC_APPLY = 1'b1;

   localparam logic [ST_W-1:0] STATUS_OK  = 2'd0;
   localparam logic [ST_W-1:0] STATUS_SAT = 2'd1;
   localparam logic [ST_W-1:0] STATUS_BAD = 2'd2;

   localparam logic [1:0] REG_COARSE = 2'd0;
   localparam logic [1:0] REG_SPB    = 2'd1;
   localparam logic [1:0] REG_FINE   = 2'd2;

   typedef struct packed {
      logic              func;
      logic [IDX_W-1:0]  idx;
      logic [CH_W-1:0]   ch;
      logic [8*W-1:0]    data;
   } item_type;

   typedef struct packed {
      logic [FC_W:0]   rem;
      logic [FC_W-1:0] quo;
   } div_type;

   function automatic logic signed [W-1:0] part_of(logic [8*W-1:0] d, int k);
      return signed'(d[W*k +: W]);
   endfunction

   // restoring division over quotient bits hi down to lo
   function automatic div_type div_part(div_type s, logic [FC_W-1:0] num,
                                        logic [FC_W-1:0] den, int hi, int lo);
      div_type r;
      r = s;
      for (int i = FC_W - 1; i >= 0; i--) begin
         if (i <= hi && i >= lo) begin
            r.rem = {r.rem[FC_W-1:0], num[i]};
            if (r.rem >= {1'b0, den}) begin
               r.rem = r.rem - {1'b0, den};
               r.quo[i] = 1'b1;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [TRI_W-1:0] tri_num(logic [ANT_W-1:0] c);
      logic [ANT_W:0]     c1;
      logic [2*ANT_W:0]   p;
      c1 = {1'b0, c} + 1'b1;
      p  = {{(ANT_W + 1){1'b0}}, c} * {{ANT_W{1'b0}}, c1};
      return TRI_W'(p >> 1);
   endfunction

   // greedy search for largest a with a*(a+1)/2 <= idx, bits hi down to lo
   function automatic logic [ANT_W-1:0] tri_part(logic [ANT_W-1:0] a,
                                                  logic [IDX_W-1:0] idx, int hi, int lo);
      logic [ANT_W-1:0] r;
      logic [ANT_W-1:0] c;
      r = a;
      for (int i = ANT_W - 1; i >= 0; i--) begin
         if (i <= hi && i >= lo) begin
            c = r;
            c[i] = 1'b1;
            if (tri_num(c) <= TRI_W'(idx)) begin
               r = c;
            end
         end
      end
      return r;
   endfunction

endpackage

// ===== hdl/jones_calibration_apply.sv =====
// Jones matrix calibration apply: solution store and pipelined A*V*B^H datapath
// One request per cycle while the result register is not waiting on rsp_tready.
// Stages: input, channel ratio division and antenna search (4), range check and
// address, memory, V*B^H multiply and round (2), A*T split multiply, sum and
// round/saturate (3). Whole pipeline holds while the result register waits on rsp_tready.
// Reset clears valid bits and sets config registers to defaults; the solution memory is not cleared.
`timescale 1ns / 1ps

module jones_calibration_apply (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // index, chan, xx_re, xx_im, xy_re, xy_im, yx_re, yx_im, yy_re, yy_im
   input  logic [jca_pkg::TDATA_W-1:0]    req_tdata,
   // func
   input  logic [0:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_baseline, out_channel, cxx_re, cxx_im, cxy_re, cxy_im, cyx_re, cyx_im,
   // cyy_re, cyy_im
   output logic [jca_pkg::TDATA_W-1:0]    rsp_tdata,
   // status
   output logic [jca_pkg::ST_W-1:0]       rsp_tuser,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [jca_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [jca_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [jca_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                           csr_pready
);

   localparam int NST = 12;
   localparam int W   = jca_pkg::W;
   localparam int IW  = jca_pkg::IDX_W;
   localparam int CW  = jca_pkg::CH_W;
   localparam int FW  = jca_pkg::FC_W;
   localparam int AW  = jca_pkg::ANT_W;
   localparam int SW  = jca_pkg::SC_W;
   localparam int MW  = jca_pkg::ADDR_W;

   // config registers
   logic [jca_pkg::COARSE_W-1:0] coarse_ff;
   logic [jca_pkg::SPB_W-1:0]    spb_ff;
   logic [FW-1:0]                fine_ff;
   logic                         csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         coarse_ff <= '0;
         spb_ff    <= jca_pkg::SPB_W'(16);
         fine_ff   <= FW'(32);
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            jca_pkg::REG_COARSE: coarse_ff <= csr_pwdata[jca_pkg::COARSE_W-1:0];
            jca_pkg::REG_SPB:    spb_ff    <= csr_pwdata[jca_pkg::SPB_W-1:0];
            jca_pkg::REG_FINE:   fine_ff   <= csr_pwdata[FW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         jca_pkg::REG_COARSE: csr_prdata = jca_pkg::CSR_DW'(coarse_ff);
         jca_pkg::REG_SPB:    csr_prdata = jca_pkg::CSR_DW'(spb_ff);
         jca_pkg::REG_FINE:   csr_prdata = jca_pkg::CSR_DW'(fine_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // config-derived ratio operands
   logic          mode;
   logic [FW-1:0] spb_ext;
   logic [FW-1:0] div_num;
   logic [FW-1:0] div_den;
   logic [SW-1:0] coarse_off;

   assign spb_ext    = FW'(spb_ff);
   assign mode       = spb_ext > fine_ff;
   assign div_num    = mode ? spb_ext : fine_ff;
   assign div_den    = mode ? fine_ff : spb_ext;
   assign coarse_off = SW'(coarse_ff) * SW'(spb_ff);

   // pipeline control
   logic           adv;
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;

   assign adv        = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = adv;

   // stage registers
   jca_pkg::item_type it0_ff, it1_ff, it2_ff, it3_ff, it4_ff, it5_ff;
   jca_pkg::item_type it0_in;
   jca_pkg::div_type  d1_ff, d1_in, d2_ff, d2_in;
   logic [AW-1:0]     ant1_ff, ant1_in, a1_2_ff, a1_2_in;
   logic [AW-1:0]     a1_3_ff, a2_3_ff, a2_3_in, a1_4_ff, a2_4_ff;
   logic [FW-1:0]     q1_2_ff, q1_2_in, q1_3_ff;
   logic [SW-1:0]     prod3_ff, prod3_in, sc4_ff, sc4_in;
   logic              bad5_ff, bad5_in, wr5_ff, wr5_in;
   logic [MW-1:0]     adra5_ff, adra5_in, adrb5_ff, adrb5_in;

   logic [8*W-1:0]    ma6_ff, mb6_ff, vis6_ff, ma7_ff, ma8_ff;
   logic [IW-1:0]     idx_ff [6:10];
   logic [CW-1:0]     ch_ff [6:10];
   logic              bad_ff [6:10];

   logic signed [63:0] pr7_ff [4][8];
   logic signed [63:0] pr7_in [4][8];
   logic signed [37:0] t8_ff [8];
   logic signed [37:0] t8_in [8];
   logic signed [50:0] ph9_ff [4][8];
   logic signed [50:0] ph9_in [4][8];
   logic signed [51:0] pl9_ff [4][8];
   logic signed [51:0] pl9_in [4][8];
   logic signed [52:0] sh10_ff [8];
   logic signed [52:0] sh10_in [8];
   logic signed [53:0] sl10_ff [8];
   logic signed [53:0] sl10_in [8];

   logic [W-1:0]             out_ff [8];
   logic [W-1:0]             out_in [8];
   logic [jca_pkg::ST_W-1:0] status_ff, status_in;
   logic [IW-1:0]            oidx_ff;
   logic [CW-1:0]            och_ff;

   logic [8*W-1:0] mem [jca_pkg::DEPTH];

   // valid chain; loads leave the pipeline at the memory stage
   always_comb begin
      vld_in    = {vld_ff[NST-2:0], req_tvalid};
      vld_in[6] = vld_ff[5] && (it5_ff.func == jca_pkg::FUNC_APPLY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 0: request register
   assign it0_in = '{func: req_tuser[0],
                     idx:  req_tdata[IW-1:0],
                     ch:   req_tdata[jca_pkg::DATA_LSB-1:IW],
                     data: req_tdata[jca_pkg::PAY_W-1:jca_pkg::DATA_LSB]};

   // stages 1..4: ratio division and antenna pair search
   always_comb begin
      d1_in   = jca_pkg::div_part('0, div_num, div_den, FW - 1, jca_pkg::DIV_SPLIT);
      ant1_in = jca_pkg::tri_part('0, it0_ff.idx, AW - 1, jca_pkg::ANT_SPLIT);
      q1_2_in = jca_pkg::div_part(d1_ff, div_num, div_den,
                                  jca_pkg::DIV_SPLIT - 1, 0).quo;
      a1_2_in = jca_pkg::tri_part(ant1_ff, it1_ff.idx, jca_pkg::ANT_SPLIT - 1, 0);
      a2_3_in = AW'(jca_pkg::TRI_W'(it2_ff.idx) - jca_pkg::tri_num(a1_2_ff));
      d2_in   = jca_pkg::div_part('0, FW'(it2_ff.ch), q1_2_ff, FW - 1,
                                  jca_pkg::DIV_SPLIT);
      prod3_in = SW'(it2_ff.ch) * SW'(q1_2_ff);
      sc4_in   = coarse_off + (mode ? prod3_ff :
                 SW'(jca_pkg::div_part(d2_ff, FW'(it3_ff.ch), q1_3_ff,
                                       jca_pkg::DIV_SPLIT - 1, 0).quo));
   end

   // stage 5: range checks and addresses
   always_comb begin
      bad5_in = (32'(it4_ff.idx) >= 32'(jca_pkg::NBASE)) || (spb_ff == '0) ||
                (fine_ff == '0) || (32'(sc4_ff) >= 32'(jca_pkg::SOL_CHANNELS));
      wr5_in  = (it4_ff.func == jca_pkg::FUNC_LOAD) &&
                (32'(it4_ff.idx) < 32'(jca_pkg::ANTENNAS)) &&
                (32'(it4_ff.ch) < 32'(jca_pkg::SOL_CHANNELS));
      if (it4_ff.func == jca_pkg::FUNC_LOAD) begin
         adra5_in = MW'(32'(it4_ff.idx[AW-1:0]) * 32'(jca_pkg::SOL_CHANNELS) +
                        32'(it4_ff.ch[jca_pkg::SOL_W-1:0]));
      end else begin
         adra5_in = MW'(32'(a1_4_ff) * 32'(jca_pkg::SOL_CHANNELS) +
                        32'(sc4_ff[jca_pkg::SOL_W-1:0]));
      end
      adrb5_in = MW'(32'(a2_4_ff) * 32'(jca_pkg::SOL_CHANNELS) +
                     32'(sc4_ff[jca_pkg::SOL_W-1:0]));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it0_ff   <= it0_in;
         it1_ff   <= it0_ff;
         it2_ff   <= it1_ff;
         it3_ff   <= it2_ff;
         it4_ff   <= it3_ff;
         it5_ff   <= it4_ff;
         d1_ff    <= d1_in;
         ant1_ff  <= ant1_in;
         q1_2_ff  <= q1_2_in;
         a1_2_ff  <= a1_2_in;
         q1_3_ff  <= q1_2_ff;
         a1_3_ff  <= a1_2_ff;
         a2_3_ff  <= a2_3_in;
         d2_ff    <= d2_in;
         prod3_ff <= prod3_in;
         a1_4_ff  <= a1_3_ff;
         a2_4_ff  <= a2_3_ff;
         sc4_ff   <= sc4_in;
         bad5_ff  <= bad5_in;
         wr5_ff   <= wr5_in;
         adra5_ff <= adra5_in;
         adrb5_ff <= adrb5_in;
      end
   end

   // stage 6: solution memory, one write and two reads
   always_ff @(posedge clock) begin
      if (adv) begin
         if (vld_ff[5] && wr5_ff) begin
            mem[adra5_ff] <= it5_ff.data;
         end
         ma6_ff <= mem[adra5_ff];
         mb6_ff <= mem[adrb5_ff];
      end
   end

   // stage 7: V * B^H partial products
   always_comb begin
      for (int e = 0; e < 4; e++) begin
         for (int j = 0; j < 2; j++) begin
            pr7_in[e][4*j+0] = jca_pkg::part_of(vis6_ff, 2*(2*(e/2)+j)) *
                               jca_pkg::part_of(mb6_ff, 2*(2*(e%2)+j));
            pr7_in[e][4*j+1] = jca_pkg::part_of(vis6_ff, 2*(2*(e/2)+j)+1) *
                               jca_pkg::part_of(mb6_ff, 2*(2*(e%2)+j)+1);
            pr7_in[e][4*j+2] = jca_pkg::part_of(vis6_ff, 2*(2*(e/2)+j)+1) *
                               jca_pkg::part_of(mb6_ff, 2*(2*(e%2)+j));
            pr7_in[e][4*j+3] = jca_pkg::part_of(vis6_ff, 2*(2*(e/2)+j)) *
                               jca_pkg::part_of(mb6_ff, 2*(2*(e%2)+j)+1);
         end
      end
   end

   // stage 8: sum and round to T
   always_comb begin
      logic signed [65:0] sr;
      logic signed [65:0] si;
      for (int e = 0; e < 4; e++) begin
         sr = 66'(pr7_ff[e][0]) + 66'(pr7_ff[e][1]) + 66'(pr7_ff[e][4]) +
              66'(pr7_ff[e][5]) + 66'sd134217728;
         si = 66'(pr7_ff[e][2]) - 66'(pr7_ff[e][3]) + 66'(pr7_ff[e][6]) -
              66'(pr7_ff[e][7]) + 66'sd134217728;
         t8_in[2*e]   = sr[65:28];
         t8_in[2*e+1] = si[65:28];
      end
   end

   // stage 9: A * T with T split in high and low halves
   always_comb begin
      logic signed [W-1:0] asel;
      logic signed [37:0]  tsel;
      logic signed [18:0]  th;
      logic signed [19:0]  tl;
      for (int f = 0; f < 4; f++) begin
         for (int k = 0; k < 2; k++) begin
            for (int m = 0; m < 4; m++) begin
               asel = (m == 0 || m == 2) ? jca_pkg::part_of(ma8_ff, 2*(2*(f/2)+k)) :
                                           jca_pkg::part_of(ma8_ff, 2*(2*(f/2)+k)+1);
               tsel = (m == 0 || m == 3) ? t8_ff[2*(2*k+f%2)] : t8_ff[2*(2*k+f%2)+1];
               th   = tsel[37:19];
               tl   = {1'b0, tsel[18:0]};
               ph9_in[f][4*k+m] = asel * th;
               pl9_in[f][4*k+m] = asel * tl;
            end
         end
      end
   end

   // stage 10: sums of the split products
   always_comb begin
      for (int f = 0; f < 4; f++) begin
         sh10_in[2*f]   = 53'(ph9_ff[f][0]) - 53'(ph9_ff[f][1]) +
                          53'(ph9_ff[f][4]) - 53'(ph9_ff[f][5]);
         sl10_in[2*f]   = 54'(pl9_ff[f][0]) - 54'(pl9_ff[f][1]) +
                          54'(pl9_ff[f][4]) - 54'(pl9_ff[f][5]);
         sh10_in[2*f+1] = 53'(ph9_ff[f][2]) + 53'(ph9_ff[f][3]) +
                          53'(ph9_ff[f][6]) + 53'(ph9_ff[f][7]);
         sl10_in[2*f+1] = 54'(pl9_ff[f][2]) + 54'(pl9_ff[f][3]) +
                          54'(pl9_ff[f][6]) + 54'(pl9_ff[f][7]);
      end
   end

   // stage 11: combine, round, saturate
   always_comb begin
      logic signed [71:0] x;
      logic signed [43:0] r;
      logic               sat;
      sat = 1'b0;
      for (int p = 0; p < 8; p++) begin
         x = (72'(sh10_ff[p]) <<< 19) + 72'(sl10_ff[p]) + 72'sd134217728;
         r = x[71:28];
         if (r > 44'sd2147483647) begin
            out_in[p] = 32'h7FFF_FFFF;
            sat = 1'b1;
         end else if (r < -44'sd2147483648) begin
            out_in[p] = 32'h8000_0000;
            sat = 1'b1;
         end else begin
            out_in[p] = r[W-1:0];
         end
         if (bad_ff[10]) begin
            out_in[p] = '0;
         end
      end
      if (bad_ff[10]) begin
         status_in = jca_pkg::STATUS_BAD;
      end else if (sat) begin
         status_in = jca_pkg::STATUS_SAT;
      end else begin
         status_in = jca_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vis6_ff    <= it5_ff.data;
         idx_ff[6]  <= it5_ff.idx;
         ch_ff[6]   <= it5_ff.ch;
         bad_ff[6]  <= bad5_ff;
         for (int s = 7; s <= 10; s++) begin
            idx_ff[s] <= idx_ff[s-1];
            ch_ff[s]  <= ch_ff[s-1];
            bad_ff[s] <= bad_ff[s-1];
         end
         ma7_ff  <= ma6_ff;
         ma8_ff  <= ma7_ff;
         pr7_ff  <= pr7_in;
         t8_ff   <= t8_in;
         ph9_ff  <= ph9_in;
         pl9_ff  <= pl9_in;
         sh10_ff <= sh10_in;
         sl10_ff <= sl10_in;
         out_ff    <= out_in;
         status_ff <= status_in;
         oidx_ff   <= idx_ff[10];
         och_ff    <= ch_ff[10];
      end
   end

   assign rsp_tvalid = vld_ff[NST-1];
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {{(jca_pkg::TDATA_W - jca_pkg::PAY_W){1'b0}},
                        out_ff[7], out_ff[6], out_ff[5], out_ff[4],
                        out_ff[3], out_ff[2], out_ff[1], out_ff[0],
                        och_ff, oidx_ff};

endmodule

// ===== hdl/jca_checker.sv =====
// Port-level checker for the Jones calibration block, bound to the top level
`timescale 1ns / 1ps
`include "jones_calibration_apply_assert.svh"

module jca_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [jca_pkg::TDATA_W-1:0] rsp_tdata,
   input logic [jca_pkg::ST_W-1:0]    rsp_tuser,
   input logic                        csr_pready
);

   // input side only backs up behind a stalled result
   `JCA_ASSERT_NOW(a_ready_stall, clock, reset, !req_tready, rsp_tvalid && !rsp_tready)

   `JCA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   `JCA_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid, (rsp_tuser == jca_pkg::STATUS_OK) || (rsp_tuser == jca_pkg::STATUS_SAT) || (rsp_tuser == jca_pkg::STATUS_BAD))

   // out-of-range requests return zero visibilities
   `JCA_ASSERT_NOW(a_bad_zero, clock, reset, rsp_tvalid && (rsp_tuser == jca_pkg::STATUS_BAD), rsp_tdata[jca_pkg::PAY_W-1:jca_pkg::DATA_LSB] == '0)

   `JCA_ASSERT_NOW(a_pready, clock, reset, 1'b1, csr_pready)

endmodule

bind jones_calibration_apply jca_checker u_jca_checker (.*);
